// ----- hw/rtl/srtf_pkg.sv -----
// Shared types, widths and sequencer states of the SRTF batch scheduler.
package srtf_pkg;

    localparam int MAX_PROC = 16;
    localparam int IDX_W    = $clog2(MAX_PROC);
    localparam int CNT_W    = $clog2(MAX_PROC + 1);
    localparam int DATA_W   = 16;
    localparam int TICK_W   = 21;
    localparam int DIFF_W   = 20;
    localparam int SUM_W    = 24;
    localparam int KEY_W    = DATA_W + IDX_W;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [DIFF_W-1:0] diff_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [KEY_W-1:0]  key_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EXEC,
        ST_OSCAN,
        ST_OCALC,
        ST_OFORM,
        ST_OSEND
    } state_t;

endpackage

// ----- hw/rtl/srtf_batch_scheduler.sv -----
// Preemptive shortest-remaining-time-first batch scheduler, top level.
//
// Usage: jobs enter on the s_ channel (arrival, burst, last_job), one per cycle
// while s_ready is high. The transaction with s_last_job set, or the sixteenth
// job, closes the batch; s_ready then stays low until the last result of the
// batch is taken. A job with zero burst completes at its own arrival.
// Scheduling runs as repeated scans: each scan walks the n stored jobs, one per
// cycle, through a single compare unit to pick the ready job with the least
// remaining time (ties: earlier arrival, then earlier load) and the next
// arrival; EXEC then moves the tick to the next completion or arrival.
// A scheduling step is thus a scan followed by EXEC, and a batch needs at most
// about 2n steps. Results leave on the m_ channel in arrival order; each is
// made by a selection scan, a subtract and a form step, and each then
// waits in the output register while m_ready is low. Totals restart per batch.
// Reset (aresetn low, synchronous) empties the batch, drops any pending result
// and returns to loading; the job stores are not cleared.
module srtf_batch_scheduler (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [15:0]                s_arrival_time,
    input  logic [15:0]                s_burst_time,
    input  logic                       s_last_job,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [4:0]                 m_job_number,
    output logic [15:0]                m_echo_arrival,
    output logic [15:0]                m_echo_burst,
    output logic [20:0]                m_completion_time,
    output logic [19:0]                m_turnaround_time,
    output logic [19:0]                m_waiting_time,
    output logic [23:0]                m_total_waiting,
    output logic [23:0]                m_total_turnaround,
    output logic                       m_last_result
);

    // job stores
    srtf_pkg::data_t arr_mem [srtf_pkg::MAX_PROC];
    srtf_pkg::data_t bur_mem [srtf_pkg::MAX_PROC];
    srtf_pkg::data_t rem_mem [srtf_pkg::MAX_PROC];
    srtf_pkg::tick_t comp_mem[srtf_pkg::MAX_PROC];

    // control registers
    srtf_pkg::state_t state_reg, state_next;
    srtf_pkg::cnt_t   job_count_reg, job_count_next;
    srtf_pkg::cnt_t   fin_reg, fin_next;
    srtf_pkg::cnt_t   out_cnt_reg, out_cnt_next;
    srtf_pkg::tick_t  tick_reg, tick_next;
    srtf_pkg::idx_t   scan_reg, scan_next;
    logic             best_vld_reg, best_vld_next;
    logic             nxt_vld_reg, nxt_vld_next;
    logic             sel_vld_reg, sel_vld_next;
    logic             prev_vld_reg, prev_vld_next;
    logic             m_valid_reg, m_valid_next;

    // datapath registers
    srtf_pkg::idx_t   best_idx_reg, best_idx_next;
    srtf_pkg::data_t  best_rem_reg, best_rem_next;
    srtf_pkg::data_t  best_arr_reg, best_arr_next;
    srtf_pkg::data_t  nxt_reg, nxt_next;
    srtf_pkg::idx_t   sel_idx_reg, sel_idx_next;
    srtf_pkg::data_t  sel_arr_reg, sel_arr_next;
    srtf_pkg::data_t  sel_bur_reg, sel_bur_next;
    srtf_pkg::tick_t  sel_comp_reg, sel_comp_next;
    srtf_pkg::key_t   prev_key_reg, prev_key_next;
    srtf_pkg::diff_t  ta_reg, ta_next;
    srtf_pkg::sum_t   tw_reg, tw_next;
    srtf_pkg::sum_t   tt_reg, tt_next;
    srtf_pkg::cnt_t   m_job_reg, m_job_next;
    srtf_pkg::data_t  m_arr_reg, m_arr_next;
    srtf_pkg::data_t  m_bur_reg, m_bur_next;
    srtf_pkg::tick_t  m_comp_reg, m_comp_next;
    srtf_pkg::diff_t  m_ta_reg, m_ta_next;
    srtf_pkg::diff_t  m_wt_reg, m_wt_next;
    logic             m_last_reg, m_last_next;

    // store write controls
    logic             load_we;
    srtf_pkg::idx_t   load_idx;
    logic             rem_we;
    srtf_pkg::idx_t   rem_waddr;
    srtf_pkg::data_t  rem_wdata;
    logic             comp_we;
    srtf_pkg::idx_t   comp_waddr;
    srtf_pkg::tick_t  comp_wdata;

    // scan read port and helpers
    srtf_pkg::data_t  a_rd, r_rd, b_rd;
    srtf_pkg::tick_t  c_rd;
    logic             scan_last;
    srtf_pkg::key_t   cur_key, sel_key;
    srtf_pkg::tick_t  gap;
    srtf_pkg::data_t  run;
    srtf_pkg::data_t  rem_new;
    srtf_pkg::tick_t  tick_new;
    srtf_pkg::cnt_t   jc_new, fin_load;
    srtf_pkg::diff_t  wt_val;

    assign a_rd      = arr_mem[scan_reg];
    assign r_rd      = rem_mem[scan_reg];
    assign b_rd      = bur_mem[scan_reg];
    assign c_rd      = comp_mem[scan_reg];
    assign scan_last = (srtf_pkg::cnt_t'(scan_reg) == job_count_reg - srtf_pkg::cnt_t'(1));
    assign cur_key   = {a_rd, scan_reg};
    assign sel_key   = {sel_arr_reg, sel_idx_reg};
    assign load_idx  = srtf_pkg::idx_t'(job_count_reg);
    assign jc_new    = job_count_reg + srtf_pkg::cnt_t'(1);
    assign fin_load  = fin_reg + srtf_pkg::cnt_t'(s_burst_time == '0);

    // run length of one scheduling step: up to the next arrival at most
    always_comb begin
        gap = srtf_pkg::tick_t'(nxt_reg) - tick_reg;
        run = best_rem_reg;
        if (nxt_vld_reg && (gap < srtf_pkg::tick_t'(best_rem_reg))) begin
            run = gap[srtf_pkg::DATA_W-1:0];
        end
        tick_new = tick_reg + srtf_pkg::tick_t'(run);
        rem_new  = best_rem_reg - run;
    end

    assign wt_val = ta_reg - srtf_pkg::diff_t'(sel_bur_reg);

    // sequencer: next state and datapath updates
    always_comb begin
        state_next     = state_reg;
        job_count_next = job_count_reg;
        fin_next       = fin_reg;
        out_cnt_next   = out_cnt_reg;
        tick_next      = tick_reg;
        scan_next      = scan_reg;
        best_vld_next  = best_vld_reg;
        nxt_vld_next   = nxt_vld_reg;
        sel_vld_next   = sel_vld_reg;
        prev_vld_next  = prev_vld_reg;
        m_valid_next   = m_valid_reg;
        best_idx_next  = best_idx_reg;
        best_rem_next  = best_rem_reg;
        best_arr_next  = best_arr_reg;
        nxt_next       = nxt_reg;
        sel_idx_next   = sel_idx_reg;
        sel_arr_next   = sel_arr_reg;
        sel_bur_next   = sel_bur_reg;
        sel_comp_next  = sel_comp_reg;
        prev_key_next  = prev_key_reg;
        ta_next        = ta_reg;
        tw_next        = tw_reg;
        tt_next        = tt_reg;
        m_job_next     = m_job_reg;
        m_arr_next     = m_arr_reg;
        m_bur_next     = m_bur_reg;
        m_comp_next    = m_comp_reg;
        m_ta_next      = m_ta_reg;
        m_wt_next      = m_wt_reg;
        m_last_next    = m_last_reg;
        load_we        = 1'b0;
        rem_we         = 1'b0;
        rem_waddr      = load_idx;
        rem_wdata      = s_burst_time;
        comp_we        = 1'b0;
        comp_waddr     = load_idx;
        comp_wdata     = srtf_pkg::tick_t'(s_arrival_time);
        s_ready        = 1'b0;

        unique case (state_reg)
            // store jobs; zero bursts finish at their arrival right away
            srtf_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    load_we        = 1'b1;
                    rem_we         = 1'b1;
                    comp_we        = (s_burst_time == '0);
                    job_count_next = jc_new;
                    fin_next       = fin_load;
                    if (s_last_job || (jc_new == srtf_pkg::cnt_t'(srtf_pkg::MAX_PROC))) begin
                        scan_next     = '0;
                        best_vld_next = 1'b0;
                        nxt_vld_next  = 1'b0;
                        sel_vld_next  = 1'b0;
                        prev_vld_next = 1'b0;
                        out_cnt_next  = '0;
                        tw_next       = '0;
                        tt_next       = '0;
                        if (fin_load == jc_new) begin
                            state_next = srtf_pkg::ST_OSCAN;
                        end else begin
                            state_next = srtf_pkg::ST_SCAN;
                        end
                    end
                end
            end

            // pick the ready job with least remaining time and the next arrival
            srtf_pkg::ST_SCAN: begin
                if (r_rd != '0) begin
                    if (srtf_pkg::tick_t'(a_rd) <= tick_reg) begin
                        if (!best_vld_reg || (r_rd < best_rem_reg) ||
                            ((r_rd == best_rem_reg) && (a_rd < best_arr_reg))) begin
                            best_vld_next = 1'b1;
                            best_idx_next = scan_reg;
                            best_rem_next = r_rd;
                            best_arr_next = a_rd;
                        end
                    end else if (!nxt_vld_reg || (a_rd < nxt_reg)) begin
                        nxt_vld_next = 1'b1;
                        nxt_next     = a_rd;
                    end
                end
                scan_next = scan_reg + srtf_pkg::idx_t'(1);
                if (scan_last) begin
                    state_next = srtf_pkg::ST_EXEC;
                end
            end

            // advance time: run the chosen job or jump to the next arrival
            srtf_pkg::ST_EXEC: begin
                scan_next     = '0;
                best_vld_next = 1'b0;
                nxt_vld_next  = 1'b0;
                state_next    = srtf_pkg::ST_SCAN;
                if (!best_vld_reg) begin
                    tick_next = srtf_pkg::tick_t'(nxt_reg);
                end else begin
                    tick_next = tick_new;
                    rem_we    = 1'b1;
                    rem_waddr = best_idx_reg;
                    rem_wdata = rem_new;
                    if (rem_new == '0) begin
                        comp_we    = 1'b1;
                        comp_waddr = best_idx_reg;
                        comp_wdata = tick_new;
                        fin_next   = fin_reg + srtf_pkg::cnt_t'(1);
                        if (fin_reg + srtf_pkg::cnt_t'(1) == job_count_reg) begin
                            sel_vld_next = 1'b0;
                            state_next   = srtf_pkg::ST_OSCAN;
                        end
                    end
                end
            end

            // find the next job in (arrival, load) order
            srtf_pkg::ST_OSCAN: begin
                if ((!prev_vld_reg || (cur_key > prev_key_reg)) &&
                    (!sel_vld_reg || (cur_key < sel_key))) begin
                    sel_vld_next  = 1'b1;
                    sel_idx_next  = scan_reg;
                    sel_arr_next  = a_rd;
                    sel_bur_next  = b_rd;
                    sel_comp_next = c_rd;
                end
                scan_next = scan_reg + srtf_pkg::idx_t'(1);
                if (scan_last) begin
                    state_next = srtf_pkg::ST_OCALC;
                end
            end

            // turnaround = completion - arrival
            srtf_pkg::ST_OCALC: begin
                ta_next    = srtf_pkg::diff_t'(sel_comp_reg - srtf_pkg::tick_t'(sel_arr_reg));
                state_next = srtf_pkg::ST_OFORM;
            end

            // form the result transaction and update the totals
            srtf_pkg::ST_OFORM: begin
                tw_next       = tw_reg + srtf_pkg::sum_t'(wt_val);
                tt_next       = tt_reg + srtf_pkg::sum_t'(ta_reg);
                m_job_next    = srtf_pkg::cnt_t'(sel_idx_reg) + srtf_pkg::cnt_t'(1);
                m_arr_next    = sel_arr_reg;
                m_bur_next    = sel_bur_reg;
                m_comp_next   = sel_comp_reg;
                m_ta_next     = ta_reg;
                m_wt_next     = wt_val;
                m_last_next   = (out_cnt_reg + srtf_pkg::cnt_t'(1) == job_count_reg);
                out_cnt_next  = out_cnt_reg + srtf_pkg::cnt_t'(1);
                prev_vld_next = 1'b1;
                prev_key_next = sel_key;
                m_valid_next  = 1'b1;
                state_next    = srtf_pkg::ST_OSEND;
            end

            // hold the result until taken
            srtf_pkg::ST_OSEND: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    scan_next    = '0;
                    sel_vld_next = 1'b0;
                    if (m_last_reg) begin
                        job_count_next = '0;
                        fin_next       = '0;
                        tick_next      = '0;
                        state_next     = srtf_pkg::ST_LOAD;
                    end else begin
                        state_next = srtf_pkg::ST_OSCAN;
                    end
                end
            end

            default: begin
                state_next = srtf_pkg::ST_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= srtf_pkg::ST_LOAD;
            job_count_reg <= '0;
            fin_reg       <= '0;
            out_cnt_reg   <= '0;
            tick_reg      <= '0;
            scan_reg      <= '0;
            best_vld_reg  <= 1'b0;
            nxt_vld_reg   <= 1'b0;
            sel_vld_reg   <= 1'b0;
            prev_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            tw_reg        <= '0;
            tt_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            job_count_reg <= job_count_next;
            fin_reg       <= fin_next;
            out_cnt_reg   <= out_cnt_next;
            tick_reg      <= tick_next;
            scan_reg      <= scan_next;
            best_vld_reg  <= best_vld_next;
            nxt_vld_reg   <= nxt_vld_next;
            sel_vld_reg   <= sel_vld_next;
            prev_vld_reg  <= prev_vld_next;
            m_valid_reg   <= m_valid_next;
            tw_reg        <= tw_next;
            tt_reg        <= tt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        best_arr_reg <= best_arr_next;
        nxt_reg      <= nxt_next;
        sel_idx_reg  <= sel_idx_next;
        sel_arr_reg  <= sel_arr_next;
        sel_bur_reg  <= sel_bur_next;
        sel_comp_reg <= sel_comp_next;
        prev_key_reg <= prev_key_next;
        ta_reg       <= ta_next;
        m_job_reg    <= m_job_next;
        m_arr_reg    <= m_arr_next;
        m_bur_reg    <= m_bur_next;
        m_comp_reg   <= m_comp_next;
        m_ta_reg     <= m_ta_next;
        m_wt_reg     <= m_wt_next;
        m_last_reg   <= m_last_next;
    end

    // job store writes
    always_ff @(posedge aclk) begin
        if (load_we) begin
            arr_mem[load_idx] <= s_arrival_time;
            bur_mem[load_idx] <= s_burst_time;
        end
        if (rem_we) begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        if (comp_we) begin
            comp_mem[comp_waddr] <= comp_wdata;
        end
    end

    // drive outputs
    assign m_valid            = m_valid_reg;
    assign m_job_number       = m_job_reg;
    assign m_echo_arrival     = m_arr_reg;
    assign m_echo_burst       = m_bur_reg;
    assign m_completion_time  = m_comp_reg;
    assign m_turnaround_time  = m_ta_reg;
    assign m_waiting_time     = m_wt_reg;
    assign m_total_waiting    = tw_reg;
    assign m_total_turnaround = tt_reg;
    assign m_last_result      = m_last_reg;

endmodule
